@@ sv/cte_pkg.sv @@
// ----------------------------------------------------------------------------
// cte_pkg: shared types, constants and tables for calendar_to_epoch_seconds
// Field widths, the cumulative month table and the century correction.
// ----------------------------------------------------------------------------
package cte_pkg;

    localparam int unsigned EpochYearOfs   = 70;
    localparam int unsigned FirstCenturyGp = 131;
    localparam int unsigned DaysPerYear    = 365;
    localparam int unsigned HoursPerDay    = 24;
    localparam int unsigned MinPerHour     = 60;
    localparam int unsigned SecPerMin      = 60;
    localparam int unsigned MonthsPerYear  = 12;
    // x / 100 == (x * 5243) >> 19 for every x below 2^11
    localparam int unsigned RecipHundred   = 5243;
    localparam int unsigned RecipShift     = 19;
    localparam int unsigned LastCentury    = 20;

    localparam int unsigned YearW   = 11;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinW    = 6;
    localparam int unsigned SecW    = 6;
    localparam int unsigned DaysW   = 21;  // signed day count, -1 .. ~723k
    localparam int unsigned EpochW  = 37;
    localparam int unsigned InDataW = 40;
    localparam int unsigned OutDataW = 40;

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
        logic [SecW-1:0]   second;
    } t_cte_in;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic                    inval;
        logic signed [DaysW-1:0] days;
        logic [HourW-1:0]        hour;
        logic [MinW-1:0]         minute;
        logic [SecW-1:0]         second;
    } t_cte_item;

    function automatic logic [8:0] month_start(input logic [MonthW-1:0] mon);
        logic [8:0] d;
        case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // true for a century year (relative to 1900, from 100 to 2000) that is not a leap year
    function automatic logic century_skip(input logic [YearW-1:0] y);
        logic skip;
        skip = 1'b0;
        for (int k = 1; k <= LastCentury; k++) begin
            if (y == YearW'(k * 100) && ((k & 3) != 1))
                skip = 1'b1;
        end
        return skip;
    endfunction

    // days dropped for skipped centuries, c = (yrs - 131) / 100
    function automatic logic [4:0] century_corr(input logic [4:0] c);
        logic [4:0] adj;
        case (c[1:0])
            2'd0:    adj = 5'd0;
            2'd1:    adj = 5'd1;
            default: adj = 5'd2;
        endcase
        return 5'(c[4:2] * 3) + 5'd1 + adj;
    endfunction

endpackage

@@ sv/cte_front.sv @@
// ----------------------------------------------------------------------------
// cte_front: request intake and day count
// Checks year and month, then builds the signed day number in two stages.
// ----------------------------------------------------------------------------
module cte_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cte_pkg::t_cte_in   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output cte_pkg::t_cte_item o_item
);
    import cte_pkg::*;

    logic [YearW-1:0] yrs;
    logic [YearW-1:0] yrs_c;
    logic [23:0]      cprod;
    logic             leap_add;
    logic             ready1;
    logic             ready2;
    logic [DaysW-1:0] days_sum;
    logic [4:0]       corr;

    logic             r1_valid;
    logic             r1_inval;
    logic [19:0]      r1_y365;
    logic [8:0]       r1_quart;
    logic             r1_cent_on;
    logic [4:0]       r1_cent;
    logic [8:0]       r1_mofs;
    logic [HourW-1:0] r1_hour;
    logic [MinW-1:0]  r1_min;
    logic [SecW-1:0]  r1_sec;

    logic             r2_valid;
    t_cte_item        r2_item;

    always_comb begin
        yrs      = i_data.year - YearW'(EpochYearOfs);
        yrs_c    = yrs - YearW'(FirstCenturyGp);
        cprod    = 24'(yrs_c) * 24'(RecipHundred);
        leap_add = (i_data.year[1:0] == 2'd0) && !century_skip(i_data.year)
                   && (i_data.month > 4'd1);
    end

    assign ready2  = !r2_valid || i_ready;
    assign ready1  = !r1_valid || ready2;
    assign o_ready = ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (ready1) begin
            r1_valid <= i_valid;
        end
        if (i_valid && ready1) begin
            r1_inval   <= (i_data.year < YearW'(EpochYearOfs)) ||
                          (i_data.month > 4'(MonthsPerYear - 1));
            r1_y365    <= 20'(yrs) * 20'(DaysPerYear);
            r1_quart   <= 9'((12'(yrs) + 12'd1) >> 2);
            r1_cent_on <= yrs >= YearW'(FirstCenturyGp);
            r1_cent    <= cprod[RecipShift+4:RecipShift];
            r1_mofs    <= month_start(i_data.month) + 9'(i_data.day) + 9'(leap_add);
            r1_hour    <= i_data.hour;
            r1_min     <= i_data.minute;
            r1_sec     <= i_data.second;
        end
    end

    always_comb begin
        corr     = r1_cent_on ? century_corr(r1_cent) : 5'd0;
        days_sum = DaysW'(r1_y365) + DaysW'(r1_quart) - DaysW'(corr)
                   + DaysW'(r1_mofs) - DaysW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (ready2) begin
            r2_valid <= r1_valid;
        end
        if (r1_valid && ready2) begin
            r2_item.inval  <= r1_inval;
            r2_item.days   <= $signed(days_sum);
            r2_item.hour   <= r1_hour;
            r2_item.minute <= r1_min;
            r2_item.second <= r1_sec;
        end
    end

    assign o_valid = r2_valid;
    assign o_item  = r2_item;

endmodule

@@ sv/cte_queue.sv @@
// ----------------------------------------------------------------------------
// cte_queue: two-entry queue between day count and seconds stages
// Lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module cte_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cte_pkg::t_cte_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output cte_pkg::t_cte_item o_item
);
    import cte_pkg::*;

    t_cte_item  r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    logic       pop;

    assign o_ready = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (push && !pop)
            n_count = r_count + 2'd1;
        else if (pop && !push)
            n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push)
                r_wr <= !r_wr;
            if (pop)
                r_rd <= !r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push)
            r_mem[r_wr] <= i_item;
    end

endmodule

@@ sv/cte_back.sv @@
// ----------------------------------------------------------------------------
// cte_back: days to seconds
// Three multiply-add stages: hours, minutes, seconds; last stage is the output.
// ----------------------------------------------------------------------------
module cte_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  cte_pkg::t_cte_item         i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [cte_pkg::EpochW-1:0] o_seconds,
    output logic                       o_inval
);
    import cte_pkg::*;

    logic               ready1;
    logic               ready2;
    logic               ready3;
    logic signed [25:0] hsum;
    logic signed [31:0] msum;
    logic signed [EpochW-1:0] ssum;

    logic               r1_valid;
    logic               r1_inval;
    logic signed [25:0] r1_hours;
    logic [MinW-1:0]    r1_min;
    logic [SecW-1:0]    r1_sec;

    logic               r2_valid;
    logic               r2_inval;
    logic signed [31:0] r2_mins;
    logic [SecW-1:0]    r2_sec;

    logic               r3_valid;
    logic               r3_inval;
    logic [EpochW-1:0]  r3_secs;

    assign ready3  = !r3_valid || i_ready;
    assign ready2  = !r2_valid || ready3;
    assign ready1  = !r1_valid || ready2;
    assign o_ready = ready1;

    always_comb begin
        hsum = 26'(i_item.days) * 26'sd24 + $signed(26'(i_item.hour));
        msum = 32'(r1_hours) * 32'(MinPerHour) + $signed(32'(r1_min));
        ssum = EpochW'(r2_mins) * EpochW'(SecPerMin) + $signed(EpochW'(r2_sec));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (ready1)
                r1_valid <= i_valid;
            if (ready2)
                r2_valid <= r1_valid;
            if (ready3)
                r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && ready1) begin
            r1_inval <= i_item.inval;
            r1_hours <= hsum;
            r1_min   <= i_item.minute;
            r1_sec   <= i_item.second;
        end
        if (r1_valid && ready2) begin
            r2_inval <= r1_inval;
            r2_mins  <= msum;
            r2_sec   <= r1_sec;
        end
        if (r2_valid && ready3) begin
            r3_inval <= r2_inval;
            // rejected dates report -1
            r3_secs  <= r2_inval ? {EpochW{1'b1}} : ssum;
        end
    end

    assign o_valid   = r3_valid;
    assign o_seconds = r3_secs;
    assign o_inval   = r3_inval;

endmodule

@@ sv/calendar_to_epoch_seconds.sv @@
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds: broken-down UTC time to seconds since 1970
// Stream converter, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes year-since-1900, month, day, hour, minute, second
//   packed in tdata. Master channel returns the 37-bit signed second count
//   in tdata and the invalid-date flag in tuser.
//   A year before 1970 or a month above 11 gives -1 with the flag set;
//   day and time fields are added as given.
//   From request to result the data passes two day-count stages, the
//   queue and three multiply-add stages ending in the output register.
//   Throughput is one request per cycle while the receiver takes results;
//   each back stage is a single multiply-add and the two-entry queue lets
//   the front keep running while the back is held.
//   When the receiver stalls, results hold in the output stage, the back
//   fills, then the queue, then the front; tready drops only then.
//   Reset empties all stages and the queue; no result is pending after it.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: year_since_1900[10:0], month_index[14:11], day_of_month[19:15],
    //        hour_of_day[24:20], minute_of_hour[30:25], second_of_minute[36:31]
    input  logic [cte_pkg::InDataW-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tdata: epoch_seconds[36:0]
    output logic [cte_pkg::OutDataW-1:0] m_axis_tdata,
    // tuser: invalid_date[0]
    output logic [0:0]                   m_axis_tuser
);
    import cte_pkg::*;

    t_cte_in           in_req;
    logic              f_valid;
    logic              f_ready;
    t_cte_item         f_item;
    logic              q_valid;
    logic              q_ready;
    t_cte_item         q_item;
    logic [EpochW-1:0] b_seconds;
    logic              b_inval;

    always_comb begin
        in_req.year   = s_axis_tdata[10:0];
        in_req.month  = s_axis_tdata[14:11];
        in_req.day    = s_axis_tdata[19:15];
        in_req.hour   = s_axis_tdata[24:20];
        in_req.minute = s_axis_tdata[30:25];
        in_req.second = s_axis_tdata[36:31];
    end

    cte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (in_req),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    cte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    cte_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_item    (q_item),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_seconds (b_seconds),
        .o_inval   (b_inval)
    );

    assign m_axis_tdata = OutDataW'(b_seconds);
    assign m_axis_tuser = b_inval;

endmodule
